### sv/debsw_pkg.sv
// ============================================================================
// debsw_pkg: shared types and constants for the debounced switch block
// Item and result layouts, register indexes, reset values and widths.
// ============================================================================
package debsw_pkg;

    // Time width range and default
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int TIME_BITS_MAX     = 64;
    localparam int OUT_TIME_W        = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_ENABLED = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RESET = 16'd20;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 136;

    typedef struct packed {
        logic                  input_enabled;
        logic [CFG_DATA_W-1:0] debounce_ms;
        logic                  pressed_level;
    } cfg_t;

    typedef struct packed {
        logic                  restart_duration;
        logic [OUT_TIME_W-1:0] now_ms;
        logic                  pin_level;
    } item_t;

    typedef struct packed {
        logic [OUT_TIME_W-1:0] release_time;
        logic [OUT_TIME_W-1:0] last_change_time;
        logic [OUT_TIME_W-1:0] last_duration;
        logic [OUT_TIME_W-1:0] current_duration;
        logic                  is_pressed;
        logic                  accepted_level;
        logic                  state_changed;
    } result_t;

endpackage

### sv/debsw_core.sv
// ============================================================================
// debsw_core: debounce state and single-pass evaluation
// Holds the debounce/duration state, evaluates one registered item per
// advance and presents the result for the output register.
// ============================================================================
module debsw_core #(
    parameter int TIME_BITS = debsw_pkg::TIME_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  debsw_pkg::cfg_t   cfg,
    input  debsw_pkg::item_t  item,
    output debsw_pkg::result_t result
);

    localparam int WIDE  = debsw_pkg::TIME_BITS_MAX;
    localparam int OUT_W = debsw_pkg::OUT_TIME_W;

    logic                 prev_sample_reg,  prev_sample_next;
    logic                 accepted_reg,     accepted_next;
    logic                 changed_reg,      changed_next;
    logic [TIME_BITS-1:0] deb_start_reg,    deb_start_next;
    logic [TIME_BITS-1:0] change_time_reg,  change_time_next;
    logic [TIME_BITS-1:0] recent_dur_reg,   recent_dur_next;
    logic [TIME_BITS-1:0] release_reg,      release_next;

    logic                 sample;
    logic [WIDE-1:0]      now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 window_done;
    logic                 take_change;
    logic [TIME_BITS-1:0] cur_dur;
    logic [WIDE-1:0]      cur_dur_w, recent_w, change_w, release_w;

    always_comb begin
        sample   = cfg.input_enabled ? item.pin_level : 1'b1;
        now_wide = WIDE'(item.now_ms);
        now_t    = now_wide[TIME_BITS-1:0];

        deb_start_next = (sample != prev_sample_reg) ? now_t : deb_start_reg;
        elapsed        = now_t - deb_start_next;
        window_done    = elapsed > TIME_BITS'(cfg.debounce_ms);
        take_change    = window_done && (sample != accepted_reg);

        prev_sample_next = sample;
        accepted_next    = take_change ? sample : accepted_reg;
        changed_next     = window_done ? take_change : changed_reg;
        recent_dur_next  = take_change ? (now_t - change_time_reg) : recent_dur_reg;
        release_next     = (take_change && (sample != cfg.pressed_level)) ? now_t
                                                                          : release_reg;
        // restart lands after the evaluation, same value either way
        change_time_next = (take_change || item.restart_duration) ? now_t
                                                                  : change_time_reg;

        cur_dur   = now_t - change_time_next;
        cur_dur_w = WIDE'(cur_dur);
        recent_w  = WIDE'(recent_dur_next);
        change_w  = WIDE'(change_time_next);
        release_w = WIDE'(release_next);

        result.state_changed    = changed_next;
        result.accepted_level   = accepted_next;
        result.is_pressed       = (accepted_next == cfg.pressed_level);
        result.current_duration = cur_dur_w[OUT_W-1:0];
        result.last_duration    = recent_w[OUT_W-1:0];
        result.last_change_time = change_w[OUT_W-1:0];
        result.release_time     = release_w[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= 1'b1;
            accepted_reg    <= 1'b0;
            changed_reg     <= 1'b0;
            deb_start_reg   <= '0;
            change_time_reg <= '0;
            recent_dur_reg  <= '0;
            release_reg     <= '0;
        end else if (advance) begin
            prev_sample_reg <= prev_sample_next;
            accepted_reg    <= accepted_next;
            changed_reg     <= changed_next;
            deb_start_reg   <= deb_start_next;
            change_time_reg <= change_time_next;
            recent_dur_reg  <= recent_dur_next;
            release_reg     <= release_next;
        end
    end

endmodule

### sv/debounced_switch_with_durations.sv
// ============================================================================
// debounced_switch_with_durations: pushbutton debouncer with timestamps
// Stream top level: input register, debounce core, result register and
// configuration registers.
// ============================================================================
// Each input transfer carries one pin sample and the current millisecond
// timestamp; each one yields exactly one result transfer with the debounced
// level, a changed flag, the current and previous state durations, the time
// of the latest accepted change and of the latest release. A level is
// accepted once it has persisted strictly longer than debounce_ms. One item
// is taken per clock while m_tready is high: the item sits in an input
// register, is evaluated by the core and lands in the result register,
// so throughput is one transfer per cycle while m_tready is high.
// s_tready follows m_tready when both registers are full. Configuration
// writes never disturb the debounce state; write them only while idle.
// Time arithmetic wraps modulo 2**TIME_BITS; time outputs are the low 32 bits.
module debounced_switch_with_durations #(
    parameter int TIME_BITS = debsw_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config write port
    input  logic                                   cfg_we,
    input  logic [debsw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [debsw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] pin_level, [32:1] now_ms, [33] restart_duration, [39:34] zero
    input  logic [debsw_pkg::S_TDATA_W-1:0]        s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] state_changed, [1] accepted_level, [2] is_pressed,
    // [34:3] current_duration, [66:35] last_duration,
    // [98:67] last_change_time, [130:99] release_time, [135:131] zero
    output logic [debsw_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int ITEM_W = $bits(debsw_pkg::item_t);
    localparam int RES_W  = $bits(debsw_pkg::result_t);

    // configuration registers
    debsw_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pressed_level <= 1'b0;
            cfg_reg.debounce_ms   <= debsw_pkg::DEBOUNCE_MS_RESET;
            cfg_reg.input_enabled <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                debsw_pkg::REG_PRESSED_LEVEL: cfg_reg.pressed_level <= cfg_wdata[0];
                debsw_pkg::REG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= cfg_wdata;
                debsw_pkg::REG_INPUT_ENABLED: cfg_reg.input_enabled <= cfg_wdata[0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // input register
    logic             in_valid_reg;
    debsw_pkg::item_t in_item_reg;

    // result register
    logic               out_valid_reg;
    debsw_pkg::result_t out_res_reg;
    debsw_pkg::result_t core_res;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;   // item moves through core
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= debsw_pkg::item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    debsw_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = debsw_pkg::M_TDATA_W'(out_res_reg[RES_W-1:0]);

endmodule

### sim/tb.sv
// ============================================================================
// tb: self-checking testbench for debounced_switch_with_durations
// Drives pin samples with timestamps over the input stream and checks every
// result against a cycle-free model of the debouncer. A directed table runs
// first, then random bounce and hold sequences under several register
// settings, with random idling on both stream sides.
// ============================================================================
module tb;

    // Register index that the block does not decode
    localparam logic [debsw_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RAND_SEGMENTS = 8;
    localparam int SEG_ITEMS     = 170;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One row of the directed table: a sample transfer or a register write.
    // typed rows carry an expected result written by hand.
    typedef struct {
        row_kind_t                         kind;
        logic [debsw_pkg::CFG_INDEX_W-1:0] idx;
        logic [debsw_pkg::CFG_DATA_W-1:0]  wdata;
        debsw_pkg::item_t                  it;
        bit                                typed;
        debsw_pkg::result_t                res;
    } stim_row_t;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [debsw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [debsw_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    // [0] pin_level, [32:1] now_ms, [33] restart_duration, [39:34] zero
    logic [debsw_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    // [0] state_changed, [1] accepted_level, [2] is_pressed,
    // [34:3] current_duration, [66:35] last_duration,
    // [98:67] last_change_time, [130:99] release_time, [135:131] zero
    logic [debsw_pkg::M_TDATA_W-1:0]   m_tdata;

    // Idle percentages of the current phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fails = 0;

    // Results owed by the block, oldest first
    debsw_pkg::result_t expected_states[$];

    // Model copy of the registers
    logic                             mdl_pressed  = 1'b0;
    logic [debsw_pkg::CFG_DATA_W-1:0] mdl_debounce = debsw_pkg::DEBOUNCE_MS_RESET;
    logic                             mdl_enable   = 1'b0;

    // Model copy of the debounce state (reset: previous sample is the
    // inverse of the reset pressed level)
    logic        mdl_prev_sample  = 1'b1;
    logic        mdl_level        = 1'b0;
    logic        mdl_changed      = 1'b0;
    logic [31:0] mdl_window_start = '0;
    logic [31:0] mdl_change_time  = '0;
    logic [31:0] mdl_recent_dur   = '0;
    logic [31:0] mdl_release      = '0;

    debounced_switch_with_durations dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Advance the model by one sample and return the result it owes.
    function automatic debsw_pkg::result_t predict_debounce(input debsw_pkg::item_t it);
        logic    sample;
        logic [31:0] elapsed;
        debsw_pkg::result_t r;
        sample = mdl_enable ? it.pin_level : 1'b1;
        // any edge on the raw sample restarts the debounce window
        if (sample != mdl_prev_sample)
            mdl_window_start = it.now_ms;
        elapsed = it.now_ms - mdl_window_start;
        if (elapsed > 32'(mdl_debounce)) begin
            if (sample != mdl_level) begin
                mdl_level       = sample;
                mdl_recent_dur  = it.now_ms - mdl_change_time;
                mdl_change_time = it.now_ms;
                mdl_changed     = 1'b1;
                if (sample != mdl_pressed)
                    mdl_release = it.now_ms;
            end else begin
                // flag only drops once a full window has passed unchanged
                mdl_changed = 1'b0;
            end
        end
        mdl_prev_sample = sample;
        if (it.restart_duration)
            mdl_change_time = it.now_ms;
        r.state_changed    = mdl_changed;
        r.accepted_level   = mdl_level;
        r.is_pressed       = (mdl_level == mdl_pressed);
        r.current_duration = it.now_ms - mdl_change_time;
        r.last_duration    = mdl_recent_dur;
        r.last_change_time = mdl_change_time;
        r.release_time     = mdl_release;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
            fails++;
        end
    endfunction

    function automatic stim_row_t item_row(input logic pin, input logic [31:0] now,
                                           input logic rst);
        stim_row_t row;
        row.kind  = ROW_ITEM;
        row.idx   = '0;
        row.wdata = '0;
        row.it.pin_level        = pin;
        row.it.now_ms           = now;
        row.it.restart_duration = rst;
        row.typed = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [debsw_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [debsw_pkg::CFG_DATA_W-1:0] wdata);
        stim_row_t row;
        row       = item_row(1'b0, '0, 1'b0);
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.wdata = wdata;
        return row;
    endfunction

    // Offer one sample; returns at the edge where the transfer happened,
    // with s_tvalid still high so back-to-back items follow without a gap.
    task automatic send_sample(input debsw_pkg::item_t it, input bit typed,
                               input debsw_pkg::result_t typed_res);
        debsw_pkg::result_t pred;
        while (roll(send_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= debsw_pkg::S_TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
        pred = predict_debounce(it);
        expected_states.push_back(typed ? typed_res : pred);
    endtask

    // Register write, only once the block has drained.
    task automatic write_register(input logic [debsw_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [debsw_pkg::CFG_DATA_W-1:0] wdata);
        s_tvalid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            debsw_pkg::REG_PRESSED_LEVEL: mdl_pressed  = wdata[0];
            debsw_pkg::REG_DEBOUNCE_MS:   mdl_debounce = wdata;
            debsw_pkg::REG_INPUT_ENABLED: mdl_enable   = wdata[0];
            default: ;  // undecoded index leaves everything alone
        endcase
    endtask

    // Result side: values are taken as they stood before the edge, and
    // m_tready gets exactly one update per edge.
    initial begin
        debsw_pkg::result_t got, exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[$bits(debsw_pkg::result_t)-1:0];
                if (expected_states.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    fails++;
                end else begin
                    exp_r = expected_states.pop_front();
                    check_field("state_changed", 32'(exp_r.state_changed),
                                32'(got.state_changed));
                    check_field("accepted_level", 32'(exp_r.accepted_level),
                                32'(got.accepted_level));
                    check_field("is_pressed", 32'(exp_r.is_pressed), 32'(got.is_pressed));
                    check_field("current_duration", exp_r.current_duration,
                                got.current_duration);
                    check_field("last_duration", exp_r.last_duration, got.last_duration);
                    check_field("last_change_time", exp_r.last_change_time,
                                got.last_change_time);
                    check_field("release_time", exp_r.release_time, got.release_time);
                end
            end
            m_tready <= !roll(recv_idle_pct);
        end
    end

    // Stimulus
    initial begin
        stim_row_t          rows[$];
        stim_row_t          row;
        debsw_pkg::item_t   it;
        logic [31:0]        t;
        logic               level;
        int unsigned        db;
        int unsigned        dt;
        int                 wait_cnt;
        logic               seg_pressed;
        logic               seg_enable;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed table ----
        // Reset settings: active low, 20 ms, input disabled (sample reads 1).
        // First sample right after reset: nothing has moved yet.
        row = item_row(1'b0, 32'd0, 1'b0);
        row.typed = 1'b1;
        row.res = '{release_time: 32'd0, last_change_time: 32'd0, last_duration: 32'd0,
                    current_duration: 32'd0, is_pressed: 1'b1, accepted_level: 1'b0,
                    state_changed: 1'b0};
        rows.push_back(row);
        // 21 ms > 20: the forced high level is taken, which is a release
        row = item_row(1'b1, 32'd21, 1'b0);
        row.typed = 1'b1;
        row.res = '{release_time: 32'd21, last_change_time: 32'd21, last_duration: 32'd21,
                    current_duration: 32'd0, is_pressed: 1'b0, accepted_level: 1'b1,
                    state_changed: 1'b1};
        rows.push_back(row);
        rows.push_back(item_row(1'b0, 32'd30, 1'b0));         // window passed, flag clears
        rows.push_back(cfg_row(debsw_pkg::REG_INPUT_ENABLED, 16'd1));
        rows.push_back(item_row(1'b0, 32'd40, 1'b0));         // press edge opens window
        rows.push_back(item_row(1'b1, 32'd45, 1'b0));         // bounce
        rows.push_back(item_row(1'b0, 32'd50, 1'b0));         // bounce back
        rows.push_back(item_row(1'b0, 32'd70, 1'b0));         // exactly 20: not yet
        rows.push_back(item_row(1'b0, 32'd71, 1'b0));         // 21: accepted press
        rows.push_back(item_row(1'b0, 32'd80, 1'b0));         // flag clears
        rows.push_back(item_row(1'b0, 32'd90, 1'b1));         // duration restart
        rows.push_back(item_row(1'b1, 32'd100, 1'b0));
        rows.push_back(item_row(1'b1, 32'd125, 1'b0));        // accepted release
        rows.push_back(cfg_row(debsw_pkg::REG_DEBOUNCE_MS, 16'd0));
        rows.push_back(item_row(1'b0, 32'd126, 1'b0));        // zero elapsed, still held
        rows.push_back(item_row(1'b0, 32'd127, 1'b0));        // one ms is enough
        // polarity flips, no reset
        rows.push_back(cfg_row(debsw_pkg::REG_PRESSED_LEVEL, 16'd1));
        rows.push_back(item_row(1'b0, 32'hFFFF_FFF0, 1'b0));
        rows.push_back(cfg_row(debsw_pkg::REG_DEBOUNCE_MS, 16'hFFFF));
        rows.push_back(item_row(1'b1, 32'hFFFF_FFFF, 1'b0));  // window opens at top
        rows.push_back(item_row(1'b1, 32'h0000_FFFF, 1'b0));  // 65536 across the wrap
        rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));        // must be ignored
        rows.push_back(item_row(1'b0, 32'h0001_0000, 1'b1));
        rows.push_back(item_row(1'b0, 32'h0002_0000, 1'b0));  // release, active high
        rows.push_back(cfg_row(debsw_pkg::REG_DEBOUNCE_MS, debsw_pkg::DEBOUNCE_MS_RESET));
        rows.push_back(cfg_row(debsw_pkg::REG_INPUT_ENABLED, 16'd0));
        rows.push_back(item_row(1'b0, 32'h0002_0100, 1'b0));  // forced high again

        send_idle_pct = 38;
        recv_idle_pct = 38;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_register(rows[i].idx, rows[i].wdata);
            end else begin
                send_sample(rows[i].it, rows[i].typed, rows[i].res);
            end
        end

        // ---- random part ----
        // Each segment: new settings, new idle phase, then mostly clean
        // hold/bounce sequences on a rising clock, with some raw noise.
        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            case (seg)
                0: begin seg_pressed = 1'b0; db = 0;     seg_enable = 1'b1; end
                1: begin seg_pressed = 1'b1; db = 3;     seg_enable = 1'b1; end
                2: begin seg_pressed = 1'b0; db = 65535; seg_enable = 1'b1; end
                3: begin seg_pressed = 1'b1; db = 5;     seg_enable = 1'b0; end
                4: begin seg_pressed = 1'b1; db = 20;    seg_enable = 1'b1; end
                5: begin seg_pressed = 1'b0; db = 1;     seg_enable = 1'b1; end
                6: begin seg_pressed = 1'b1; db = 65535; seg_enable = 1'b1; end
                default: begin
                    seg_pressed = 1'b0;
                    db = $urandom_range(40, 2);
                    seg_enable = 1'b1;
                end
            endcase
            write_register(debsw_pkg::REG_PRESSED_LEVEL,
                           debsw_pkg::CFG_DATA_W'(seg_pressed));
            write_register(debsw_pkg::REG_DEBOUNCE_MS, debsw_pkg::CFG_DATA_W'(db));
            write_register(debsw_pkg::REG_INPUT_ENABLED,
                           debsw_pkg::CFG_DATA_W'(seg_enable));

            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 86; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 86; end
                default: begin send_idle_pct = 38; recv_idle_pct = 38; end
            endcase

            // odd segments start anywhere, even ones just below the wrap
            t = seg[0] ? $urandom() : 32'hFFFF_FFFF - $urandom_range(2000);
            level = $urandom_range(1);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(99) < 12) begin
                    it.pin_level        = $urandom_range(1);
                    it.now_ms           = $urandom();
                    it.restart_duration = $urandom_range(1);
                end else begin
                    if ($urandom_range(7) == 0)
                        level = ~level;
                    case ($urandom_range(9))
                        0: dt = db + 1 + $urandom_range(2);  // just past the window
                        1: dt = db;                          // right on the boundary
                        default: dt = $urandom_range(db / 3 + 1);
                    endcase
                    t = t + dt;
                    it.pin_level        = ($urandom_range(5) == 0) ? ~level : level;
                    it.now_ms           = t;
                    it.restart_duration = ($urandom_range(19) == 0);
                end
                send_sample(it, 1'b0, '0);
            end
        end

        // ---- drain and verdict ----
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (expected_states.size() != 0 && wait_cnt < 20000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (10) @(posedge aclk);
        if (expected_states.size() != 0) begin
            $error("%0d expected results never arrived", expected_states.size());
            fails++;
        end
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
sv/debsw_pkg.sv
sv/debsw_core.sv
sv/debounced_switch_with_durations.sv
sim/tb.sv
